[rtl/sorted_key_binary_search_unit_macros.svh]
// ---------------------------------------------------------------------------
// sorted key binary search unit: assertion macros
// shared concurrent assertion forms used by the rtl
// ---------------------------------------------------------------------------
`ifndef SORTED_KEY_BINARY_SEARCH_UNIT_MACROS_SVH
`define SORTED_KEY_BINARY_SEARCH_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SKBS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SKBS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/skbs_pkg.sv]
// ---------------------------------------------------------------------------
// skbs_pkg
// transaction types and codes of the sorted key binary search unit
// ---------------------------------------------------------------------------
package skbs_pkg;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_SEARCH = 2'd2;

    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_FULL  = 2'd1;
    localparam logic [1:0] ERR_ORDER = 2'd2;

    localparam int KEY_FIELD_W = 24;
    localparam int POS_W       = 8;

    typedef struct packed {
        logic [1:0]             operation;
        logic [KEY_FIELD_W-1:0] key;
    } in_t;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
        logic [1:0]       error_code;
    } out_t;

endpackage

[rtl/skbs_ram.sv]
// ---------------------------------------------------------------------------
// skbs_ram
// generic simple dual port ram, one write port, one registered read port
// ---------------------------------------------------------------------------
module skbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/sorted_key_binary_search_unit.sv]
// ---------------------------------------------------------------------------
// sorted_key_binary_search_unit
// sorted key table with append, clear and binary search lookup
// ---------------------------------------------------------------------------
//
//  channel  | direction | ports                     | content
//  ---------+-----------+---------------------------+----------------------------
//  s_       | in        | s_valid, s_ready, s_data  | operation, key
//  m_       | out       | m_valid, m_ready, m_data  | found, position, error_code
//
//  a clear or append runs through S_EXEC and S_DONE; a search runs S_EXEC, then
//  S_LOOP and S_CMP per probe, a last S_LOOP, S_FIN and S_DONE; S_DONE waits for
//  a free or emptying output register; the input reopens as the result is loaded
//  a search's length is set by its loop: each probe is one read of the key ram
//  and one compare on its registered data
//  one transaction is in work at a time; a finished result sits in the output
//  register, so the next transaction is accepted while the result waits
//  synchronous active-low reset empties the table; the ram is not cleared,
//  entries at or above the count never take part in a result
//
`include "sorted_key_binary_search_unit_macros.svh"

module sorted_key_binary_search_unit #(
    parameter int TABLE_DEPTH = 256,
    parameter int KEY_CHARS   = 3
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  skbs_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output skbs_pkg::out_t m_data
);

    import skbs_pkg::*;

    // key width actually stored, capped by the key field
    localparam int KEY_W = (8 * KEY_CHARS < KEY_FIELD_W) ? 8 * KEY_CHARS : KEY_FIELD_W;
    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_LOOP = 6'b000100,
        S_CMP  = 6'b001000,
        S_FIN  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    // control state
    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] last_key_reg, last_key_next;
    logic             m_valid_reg, m_valid_next;

    // working registers of the transaction in flight
    logic [1:0]       op_reg, op_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] lo_reg, lo_next;
    logic [CNT_W-1:0] hi_reg, hi_next;
    out_t             res_reg, res_next;
    out_t             m_data_reg, m_data_next;

    // key ram ports
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [KEY_W-1:0] ram_rdata;

    logic [CNT_W-1:0] mid;
    logic             table_full;
    logic             out_of_order;
    logic [CNT_W+POS_W-1:0] count_pos_ext;
    logic [CNT_W+POS_W-1:0] lo_pos_ext;

    skbs_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // midpoint of the open search window [lo, hi)
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);

    assign table_full   = (count_reg == DEPTH_CNT);
    assign out_of_order = (count_reg != '0) && (key_reg < last_key_reg);

    // position wraps to its low byte on deep tables
    assign count_pos_ext = {{POS_W{1'b0}}, count_reg};
    assign lo_pos_ext    = {{POS_W{1'b0}}, lo_reg};

    // append writes at the current count; searches only run between appends,
    // so no read that a search uses overlaps a write to the same entry
    assign ram_we    = (state_reg == S_EXEC) && (op_reg == OP_APPEND)
                       && !table_full && !out_of_order;
    assign ram_waddr = count_reg[AW-1:0];

    // probe the midpoint while the window is open, else fetch the final candidate
    // (lo may reach the depth; that read is discarded by the count check)
    assign ram_raddr = (lo_reg < hi_reg) ? mid[AW-1:0] : lo_reg[AW-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        last_key_next = last_key_reg;
        m_valid_next  = m_valid_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        res_next      = res_reg;
        m_data_next   = m_data_reg;

        // result taken downstream
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_data.operation;
                    key_next   = s_data.key[KEY_W-1:0];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next   = '{found: 1'b0, position: '0, error_code: ERR_OK};
                state_next = S_DONE;
                case (op_reg)
                    OP_CLEAR: begin
                        count_next    = '0;
                        last_key_next = '0;
                    end
                    OP_APPEND: begin
                        if (table_full) begin
                            res_next.error_code = ERR_FULL;
                        end else if (out_of_order) begin
                            res_next.error_code = ERR_ORDER;
                        end else begin
                            res_next.position = count_pos_ext[POS_W-1:0];
                            count_next        = count_reg + 1'b1;
                            last_key_next     = key_reg;
                        end
                    end
                    OP_SEARCH: begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = S_LOOP;
                    end
                    default: begin
                        // unused code: no state change, empty result
                    end
                endcase
            end
            S_LOOP: begin
                // read issued here, see ram_raddr
                if (lo_reg < hi_reg) begin
                    state_next = S_CMP;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_CMP: begin
                if (ram_rdata < key_reg) begin
                    lo_next = mid + 1'b1;
                end else begin
                    hi_next = mid;
                end
                state_next = S_LOOP;
            end
            S_FIN: begin
                res_next = '{found: 1'b0, position: '0, error_code: ERR_OK};
                if ((lo_reg < count_reg) && (ram_rdata == key_reg)) begin
                    res_next.found    = 1'b1;
                    res_next.position = lo_pos_ext[POS_W-1:0];
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is free or being emptied
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            last_key_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            last_key_reg <= last_key_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    // table never holds more entries than the ram has
    `SKBS_ASSERT_NOW(a_count_bound, aclk, aresetn, 1'b1, count_reg <= DEPTH_CNT,
        "entry count beyond table depth")

    // a compare only ever follows a probe of an open window
    `SKBS_ASSERT_NOW(a_cmp_window, aclk, aresetn, state_reg == S_CMP, lo_reg < hi_reg,
        "compare with an empty search window")

    // a hit never carries an error
    `SKBS_ASSERT_NOW(a_found_ok, aclk, aresetn, m_valid_reg && m_data_reg.found,
        m_data_reg.error_code == ERR_OK, "found result with error code")

    // an accepted append grows the table by exactly one
    `SKBS_ASSERT_NEXT(a_append_count, aclk, aresetn, ram_we,
        count_reg == $past(count_reg) + 1'b1, "append did not advance count")

endmodule

[sim/sorted_key_binary_search_unit_tb.sv]
// ---------------------------------------------------------------------------
// sorted_key_binary_search_unit_tb
// drives clear, append and search transactions into the key table and checks
// every reply against a typed reply or an in-bench shadow table with its
// own lower-bound search; a short table of directed transactions comes first,
// followed by random fill/search episodes with random idling on both channels
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_key_binary_search_unit_tb;

    import skbs_pkg::*;

    // table size of the block under test (default parameter)
    localparam int TABLE_DEPTH = 256;
    localparam int SHADOW_AW   = $clog2(TABLE_DEPTH);

    // operation code the block does not use; must still answer with a clean reply
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS    = 900;
    localparam int HOLD_OFF_CYCLES = 400;
    // every transaction yields one reply, so the settle time only has to cover
    // one full-table search plus the output register
    localparam int SETTLE_CYCLES   = 40;
    localparam int DRAIN_LIMIT     = 20000;
    // slowest legal run: ~1200 transactions, each with a full-table search,
    // the longest sender gap and the longest receiver stall, plus one hold-off;
    // the limit covers that several times over
    localparam int CYCLE_LIMIT     = 600000;
    localparam int REPORT_LIMIT    = 30;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    // one row of the directed table: the transaction and, where it is obvious,
    // the reply typed in by hand
    typedef struct packed {
        in_t  item;
        logic golden_given;
        out_t golden;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 23;

    // row layout: operation, key, typed flag, found, position, error code
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        {OP_SEARCH, 24'h000000, TYPED,     1'b0, 8'd0, ERR_OK},    // search on empty table
        {OP_UNUSED, 24'hFFFFFF, TYPED,     1'b0, 8'd0, ERR_OK},    // unused operation code
        {OP_APPEND, 24'h000000, TYPED,     1'b0, 8'd0, ERR_OK},    // smallest key
        {OP_APPEND, 24'h000000, TYPED,     1'b0, 8'd1, ERR_OK},    // equal key is in order
        {OP_APPEND, 24'h414243, TYPED,     1'b0, 8'd2, ERR_OK},
        {OP_APPEND, 24'h414243, TYPED,     1'b0, 8'd3, ERR_OK},
        {OP_APPEND, 24'h414242, TYPED,     1'b0, 8'd0, ERR_ORDER}, // one below last key
        {OP_APPEND, 24'hFFFFFF, TYPED,     1'b0, 8'd4, ERR_OK},    // largest key
        {OP_APPEND, 24'h000001, TYPED,     1'b0, 8'd0, ERR_ORDER},
        {OP_SEARCH, 24'h000000, TYPED,     1'b1, 8'd0, ERR_OK},    // duplicate, lowest index
        {OP_SEARCH, 24'h414243, TYPED,     1'b1, 8'd2, ERR_OK},    // duplicate, lowest index
        {OP_SEARCH, 24'hFFFFFF, TYPED,     1'b1, 8'd4, ERR_OK},    // last entry
        {OP_SEARCH, 24'h414244, TYPED,     1'b0, 8'd0, ERR_OK},    // miss between entries
        {OP_SEARCH, 24'h800000, PREDICTED, 11'd0},
        {OP_UNUSED, 24'h000000, TYPED,     1'b0, 8'd0, ERR_OK},
        {OP_CLEAR,  24'hFFFFFF, TYPED,     1'b0, 8'd0, ERR_OK},    // key ignored on clear
        {OP_SEARCH, 24'h000000, TYPED,     1'b0, 8'd0, ERR_OK},    // stale entries gone
        {OP_APPEND, 24'h7FFFFF, TYPED,     1'b0, 8'd0, ERR_OK},    // last key reset by clear
        {OP_SEARCH, 24'h7FFFFF, TYPED,     1'b1, 8'd0, ERR_OK},
        {OP_APPEND, 24'h7FFFFE, TYPED,     1'b0, 8'd0, ERR_ORDER},
        {OP_CLEAR,  24'h000000, TYPED,     1'b0, 8'd0, ERR_OK},
        {OP_APPEND, 24'h123456, PREDICTED, 11'd0},
        {OP_SEARCH, 24'h123456, PREDICTED, 11'd0}
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data  = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;

    // shadow copy of the block's table, advanced at each accepted transaction
    logic [23:0] shadow_keys [TABLE_DEPTH];
    int unsigned shadow_count    = 0;
    logic [23:0] shadow_last_key = '0;

    // replies the block still owes, oldest first
    out_t awaited_replies [$];

    int unsigned offered_count    = 0;
    int unsigned error_count      = 0;
    int unsigned cycle_count      = 0;
    bit          burst_mode       = 1'b0;
    bit          hold_off_request = 1'b0;

    sorted_key_binary_search_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // expected reply of the table for one transaction; updates the shadow state
    function automatic out_t predict_table_reply(input in_t item);
        out_t        reply;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        reply = '0;
        case (item.operation)
            OP_CLEAR: begin
                shadow_count    = 0;
                shadow_last_key = '0;
            end
            OP_APPEND: begin
                if (shadow_count >= TABLE_DEPTH) begin
                    reply.error_code = ERR_FULL;          // full beats out of order
                end else if (shadow_count > 0 && item.key < shadow_last_key) begin
                    reply.error_code = ERR_ORDER;
                end else begin
                    shadow_keys[SHADOW_AW'(shadow_count)] = item.key;
                    shadow_last_key                       = item.key;
                    reply.position                        = POS_W'(shadow_count);
                    shadow_count++;
                end
            end
            OP_SEARCH: begin
                // lower bound: first entry not below the key
                lo = 0;
                hi = shadow_count;
                while (lo < hi) begin
                    mid = lo + ((hi - lo) >> 1);
                    if (shadow_keys[SHADOW_AW'(mid)] < item.key)
                        lo = mid + 1;
                    else
                        hi = mid;
                end
                if (lo < shadow_count && shadow_keys[SHADOW_AW'(lo)] == item.key) begin
                    reply.found    = 1'b1;
                    reply.position = POS_W'(lo);
                end
            end
            default: begin
                // unused code: no state change, empty reply
            end
        endcase
        return reply;
    endfunction

    // next key of an ascending run; equal keys are allowed and saturate at the top
    function automatic logic [23:0] next_ascending_key(input int unsigned max_step,
                                                       input int unsigned base_max);
        int unsigned r;
        int unsigned step;
        logic [24:0] sum;
        if (shadow_count == 0)
            return 24'($urandom_range(0, base_max));
        r = $urandom_range(0, 4);
        if (r == 0)
            step = 0;
        else if (r < 3)
            step = $urandom_range(1, 255);
        else
            step = $urandom_range(1, max_step);
        sum = {1'b0, shadow_last_key} + 25'(step);
        return sum[24] ? 24'hFFFFFF : sum[23:0];
    endfunction

    // search key: mostly a stored key, some neighbors of one, some random
    function automatic logic [23:0] search_probe_key();
        logic [23:0] k;
        int unsigned r;
        r = $urandom_range(0, 9);
        if (shadow_count == 0 || r >= 8)
            return 24'($urandom);
        k = shadow_keys[SHADOW_AW'($urandom_range(0, shadow_count - 1))];
        if (r == 6)
            return k + 24'd1;
        if (r == 7)
            return k - 24'd1;
        return k;
    endfunction

    // key strictly below the last appended key, where one exists
    function automatic logic [23:0] stale_key();
        if (shadow_last_key == '0)
            return '0;
        return 24'($urandom_range(0, shadow_last_key - 24'd1));
    endfunction

    // offer one transaction and wait for the handshake; the expectation is
    // taken at the accepting edge so it follows acceptance order exactly.
    // valid is left high after acceptance when no gap follows, so the next
    // call only rewrites the payload
    task automatic offer_item(input in_t item, input logic golden_given, input out_t golden);
        out_t        predicted;
        int unsigned gap;
        s_valid <= 1'b1;
        s_data  <= item;
        do
            @(posedge aclk);
        while (!s_ready);
        predicted = predict_table_reply(item);
        awaited_replies.push_back(golden_given ? golden : predicted);
        offered_count++;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic offer_random(input logic [1:0] operation, input logic [23:0] key);
        offer_item({operation, key}, PREDICTED, '0);
    endtask

    // reply side: random stalls, bursts with ready held high, and one long
    // hold-off that lets the block back up into its input
    initial begin : reply_sink
        int unsigned stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            @(posedge aclk);
            if (hold_off_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_request = 1'b0;
                m_ready <= 1'b1;
            end else if (burst_mode) begin
                m_ready <= 1'b1;
            end else begin
                stall = pick_gap();
                if (stall == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                    m_ready <= 1'b1;
                end
            end
        end
    end

    task automatic check_field(input string field_name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            if (error_count < REPORT_LIMIT)
                $display("%0t ns: %s mismatch, expected %0h, got %0h",
                         $time, field_name, want, got);
            error_count++;
        end
    endtask

    // reply checker: values seen here are the ones present before the edge
    always @(posedge aclk) begin : reply_check
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_replies.size() == 0) begin
                if (error_count < REPORT_LIMIT)
                    $display("%0t ns: unexpected reply, expected none, got %0h",
                             $time, m_data);
                error_count++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("found",      32'(want.found),      32'(m_data.found));
                check_field("position",   32'(want.position),   32'(m_data.position));
                check_field("error_code", 32'(want.error_code), 32'(m_data.error_code));
            end
        end
    end

    initial begin : stimulus
        int unsigned episode;
        int unsigned n_appends;
        int unsigned r;
        int unsigned drain_wait;
        bit          fill_episode;

        // synchronous reset, released once
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: extremes, duplicates, order errors, clear, unused code
        foreach (directed_rows[i])
            offer_item(directed_rows[i].item, directed_rows[i].golden_given,
                       directed_rows[i].golden);

        // random part: episodes of a (mostly) fresh table, an ascending load with
        // random content and noise, then a run of searches
        episode = 0;
        while (offered_count < DIRECTED_ROWS + RANDOM_ITEMS) begin
            episode++;
            burst_mode   = ($urandom_range(0, 4) == 0);
            fill_episode = (episode == 2) || ($urandom_range(0, 11) == 0);
            // receiver goes quiet while the sender keeps going
            if (episode == 1)
                hold_off_request = 1'b1;

            if (fill_episode || $urandom_range(0, 4) != 0)
                offer_random(OP_CLEAR, 24'($urandom));

            if (fill_episode) begin
                // load to the last slot so positions reach 255
                while (shadow_count < TABLE_DEPTH)
                    offer_random(OP_APPEND, next_ascending_key(24'h3FFF, 24'h7FFFFF));
                // appends to a full table, in and out of order
                offer_random(OP_APPEND, 24'hFFFFFF);
                offer_random(OP_APPEND, stale_key());
                offer_random(OP_APPEND, 24'($urandom));
                repeat (24)
                    offer_random(OP_SEARCH, search_probe_key());
            end else begin
                n_appends = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4)
                                                        : $urandom_range(5, 40);
                repeat (n_appends) begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        offer_random(OP_CLEAR, 24'($urandom));
                    else if (r < 3 && shadow_count > 0)
                        offer_random(OP_APPEND, stale_key());
                    else if (r < 6)
                        offer_random(OP_SEARCH, search_probe_key());
                    else if (r == 6)
                        offer_random(OP_UNUSED, 24'($urandom));
                    else
                        offer_random(OP_APPEND, next_ascending_key(24'hFFFFF, 24'hFFFFFF));
                end
                repeat ($urandom_range(5, 25)) begin
                    r = $urandom_range(0, 19);
                    if (r == 0)
                        offer_random(OP_UNUSED, 24'($urandom));
                    else if (r == 1)
                        offer_random(OP_APPEND, next_ascending_key(24'hFFFFF, 24'hFFFFFF));
                    else
                        offer_random(OP_SEARCH, search_probe_key());
                end
            end

            // sender pause until the block has answered everything; at least one
            // edge passes so valid is never driven twice at one edge
            if (episode == 3 || $urandom_range(0, 7) == 0) begin
                s_valid <= 1'b0;
                do
                    @(posedge aclk);
                while (awaited_replies.size() != 0);
            end
        end

        s_valid    <= 1'b0;
        burst_mode  = 1'b0;

        // drain, then give a stray reply time to show up
        drain_wait = 0;
        while (awaited_replies.size() != 0 && drain_wait < DRAIN_LIMIT) begin
            @(posedge aclk);
            drain_wait++;
        end
        if (awaited_replies.size() != 0) begin
            $display("%0t ns: %0d replies never arrived, expected 0 outstanding, got %0d",
                     $time, awaited_replies.size(), awaited_replies.size());
            error_count++;
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/skbs_pkg.sv
rtl/skbs_ram.sv
rtl/sorted_key_binary_search_unit.sv
sim/sorted_key_binary_search_unit_tb.sv
